### rtl/i128alu_pkg.sv
package i128alu_pkg;

    localparam int unsigned WORD_W = 128;
    localparam int unsigned HALF_W = 64;
    localparam int unsigned LIMB_W = 32;
    localparam int unsigned LIMBS  = WORD_W / LIMB_W;
    localparam int unsigned DIAGS  = 2 * LIMBS - 1;
    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned PP_W   = 2 * LIMB_W;
    localparam int unsigned DIAG_W = PP_W + 2;

    localparam int unsigned ACT_W    = 3;
    localparam int unsigned S_DATA_W = 264;
    localparam int unsigned M_DATA_W = 136;

    typedef enum logic [ACT_W-1:0] {
        ACT_MUL = 3'd0,
        ACT_ADD = 3'd1,
        ACT_SUB = 3'd2,
        ACT_NEG = 3'd3,
        ACT_ABS = 3'd4
    } action_t;

    // what rides beside the multiplier for each request
    typedef struct packed {
        logic              is_mul;
        logic              neg;
        logic [WORD_W-1:0] res;
        logic              ovf;
    } side_t;

    // per-stage load enables of the multiplier pipe
    typedef struct packed {
        logic en_pp;
        logic en_diag;
        logic en_part;
        logic en_sum;
    } mul_ctl_t;

endpackage

### rtl/i128alu_mul.sv
module i128alu_mul (
    input  logic                               aclk,
    input  i128alu_pkg::mul_ctl_t              ctl,
    input  logic [i128alu_pkg::WORD_W-1:0]     mag_a,
    input  logic [i128alu_pkg::WORD_W-1:0]     mag_b,
    output logic [i128alu_pkg::PROD_W-1:0]     prod
);

    logic [i128alu_pkg::PP_W-1:0]   pp_reg   [i128alu_pkg::LIMBS][i128alu_pkg::LIMBS];
    logic [i128alu_pkg::PP_W-1:0]   pp_next  [i128alu_pkg::LIMBS][i128alu_pkg::LIMBS];
    logic [i128alu_pkg::DIAG_W-1:0] diag_reg [i128alu_pkg::DIAGS];
    logic [i128alu_pkg::DIAG_W-1:0] diag_next[i128alu_pkg::DIAGS];
    logic [i128alu_pkg::PROD_W-1:0] even_reg, even_next;
    logic [i128alu_pkg::PROD_W-1:0] odd_reg, odd_next;
    logic [i128alu_pkg::PROD_W-1:0] prod_reg, prod_next;

    // 32x32 limb products
    always_comb begin
        for (int i = 0; i < i128alu_pkg::LIMBS; i++) begin
            for (int j = 0; j < i128alu_pkg::LIMBS; j++) begin
                pp_next[i][j] =
                    i128alu_pkg::PP_W'(mag_a[i*i128alu_pkg::LIMB_W +: i128alu_pkg::LIMB_W]) *
                    i128alu_pkg::PP_W'(mag_b[j*i128alu_pkg::LIMB_W +: i128alu_pkg::LIMB_W]);
            end
        end
    end

    // products of equal weight summed per diagonal
    always_comb begin
        for (int k = 0; k < i128alu_pkg::DIAGS; k++) begin
            diag_next[k] = '0;
        end
        for (int i = 0; i < i128alu_pkg::LIMBS; i++) begin
            for (int j = 0; j < i128alu_pkg::LIMBS; j++) begin
                diag_next[i+j] = diag_next[i+j] + i128alu_pkg::DIAG_W'(pp_reg[i][j]);
            end
        end
    end

    // even diagonals barely overlap, odd ones likewise
    always_comb begin
        even_next = '0;
        odd_next  = '0;
        for (int k = 0; k < i128alu_pkg::DIAGS; k++) begin
            if (k % 2 == 0) begin
                even_next = even_next +
                    (i128alu_pkg::PROD_W'(diag_reg[k]) << (k * i128alu_pkg::LIMB_W));
            end else begin
                odd_next = odd_next +
                    (i128alu_pkg::PROD_W'(diag_reg[k]) << (k * i128alu_pkg::LIMB_W));
            end
        end
    end

    assign prod_next = even_reg + odd_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en_pp) begin
            pp_reg <= pp_next;
        end
        if (ctl.en_diag) begin
            diag_reg <= diag_next;
        end
        if (ctl.en_part) begin
            even_reg <= even_next;
            odd_reg  <= odd_next;
        end
        if (ctl.en_sum) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/int128_checked_alu.sv
// channel   direction  tdata fields (lsb first)                               extra
// s_        in         action[2:0] lhs_lo lhs_hi rhs_lo rhs_hi                  -
// m_        out        result_low result_high overflow                          -
//
// one request accepted per cycle while the output is not stalled; every request gives one result
// stages in order: operand/simple-op stage, limb products, diagonal sums,
// even/odd partial sums, 256-bit product sum, then the output register
// the 16 limb multipliers and the 256-bit final add set the stage depth
// aresetn (synchronous, active low) clears only the valid bits
// a stalled output holds its result; empty stages keep filling behind it
module int128_checked_alu (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[2:0], lhs_lo[66:3], lhs_hi[130:67], rhs_lo[194:131],
    // rhs_hi[258:195], zero pad[263:259]
    input  logic [i128alu_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_low[63:0], result_high[127:64], overflow[128], zero pad[135:129]
    output logic [i128alu_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int unsigned W    = i128alu_pkg::WORD_W;
    localparam int unsigned H    = i128alu_pkg::HALF_W;
    localparam int unsigned AW   = i128alu_pkg::ACT_W;
    localparam int unsigned LAST = 5;   // last stage before the output register

    // request fields
    logic [AW-1:0]  act_bits;
    logic [W-1:0]   op_a, op_b, neg_a, neg_b, sum_ab, dif_ab;
    logic           a_is_min;
    i128alu_pkg::side_t side_next;

    assign act_bits = s_tdata[AW-1:0];
    assign op_a     = {s_tdata[AW+2*H-1 -: H], s_tdata[AW+H-1 -: H]};
    assign op_b     = {s_tdata[AW+4*H-1 -: H], s_tdata[AW+3*H-1 -: H]};

    assign neg_a    = W'(0) - op_a;
    assign neg_b    = W'(0) - op_b;
    assign sum_ab   = op_a + op_b;
    assign dif_ab   = op_a - op_b;
    assign a_is_min = op_a[W-1] && (op_a[W-2:0] == '0);

    // simple ops finish here; multiply only records the product sign
    always_comb begin
        side_next        = '0;
        side_next.neg    = op_a[W-1] ^ op_b[W-1];
        unique case (i128alu_pkg::action_t'(act_bits))
            i128alu_pkg::ACT_MUL: begin
                side_next.is_mul = 1'b1;
            end
            i128alu_pkg::ACT_ADD: begin
                side_next.res = sum_ab;
                side_next.ovf = (op_a[W-1] == op_b[W-1]) && (sum_ab[W-1] != op_a[W-1]);
            end
            i128alu_pkg::ACT_SUB: begin
                side_next.res = dif_ab;
                side_next.ovf = (op_a[W-1] != op_b[W-1]) && (dif_ab[W-1] != op_a[W-1]);
            end
            i128alu_pkg::ACT_NEG: begin
                side_next.res = neg_a;
                side_next.ovf = a_is_min;
            end
            i128alu_pkg::ACT_ABS: begin
                side_next.res = op_a[W-1] ? neg_a : op_a;
                side_next.ovf = a_is_min;
            end
            default: begin
                // undefined actions give zero and no overflow
                side_next = '0;
            end
        endcase
    end

    // pipeline control: a stage loads when it is empty or its successor loads
    logic [LAST+1:1]        adv;
    logic [LAST:1]          valid_reg;
    i128alu_pkg::side_t     side_reg [1:LAST];
    logic [W-1:0]           mag_a_reg, mag_b_reg;
    logic                   m_tvalid_reg;
    logic [W-1:0]           res_reg, res_next;
    logic                   ovf_reg, ovf_next;
    i128alu_pkg::mul_ctl_t  mul_ctl;
    logic [i128alu_pkg::PROD_W-1:0] prod;

    always_comb begin
        adv[LAST+1] = !m_tvalid_reg || m_tready;
        for (int k = LAST; k >= 1; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[1];

    assign mul_ctl.en_pp   = adv[2];
    assign mul_ctl.en_diag = adv[3];
    assign mul_ctl.en_part = adv[4];
    assign mul_ctl.en_sum  = adv[5];

    i128alu_mul u_mul (
        .aclk  (aclk),
        .ctl   (mul_ctl),
        .mag_a (mag_a_reg),
        .mag_b (mag_b_reg),
        .prod  (prod)
    );

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= LAST; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (adv[LAST+1]) begin
                m_tvalid_reg <= valid_reg[LAST];
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            side_reg[1] <= side_next;
            mag_a_reg   <= op_a[W-1] ? neg_a : op_a;
            mag_b_reg   <= op_b[W-1] ? neg_b : op_b;
        end
        for (int k = 2; k <= LAST; k++) begin
            if (adv[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (adv[LAST+1]) begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    // multiply: range check on the full magnitude product, then apply sign
    logic prod_hi_set;
    assign prod_hi_set = |prod[i128alu_pkg::PROD_W-1:W];

    always_comb begin
        if (side_reg[LAST].is_mul) begin
            if (side_reg[LAST].neg) begin
                // magnitude up to 2^127 is fine for a negative product
                ovf_next = prod_hi_set || (prod[W-1] && (prod[W-2:0] != '0));
                res_next = W'(0) - prod[W-1:0];
            end else begin
                ovf_next = prod_hi_set || prod[W-1];
                res_next = prod[W-1:0];
            end
        end else begin
            ovf_next = side_reg[LAST].ovf;
            res_next = side_reg[LAST].res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, ovf_reg, res_reg};

    // a free output never holds back the input
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output free");

    // every accepted request lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[1])
        else $error("accepted request lost at first stage");

    // absolute value without overflow is never negative
    a_abs_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv[1] && s_tvalid &&
         (i128alu_pkg::action_t'(act_bits) == i128alu_pkg::ACT_ABS) && !side_next.ovf)
        |-> !side_next.res[W-1])
        else $error("absolute value came out negative");

    // a stalled output keeps the last stage full
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[LAST] && m_tvalid && !m_tready) |=> valid_reg[LAST])
        else $error("last stage dropped under stall");

endmodule
